>>> design/sdec_pkg.sv
// Package for the signed integer to decimal text converter.
// Holds the controller state type, the command and status structs and the
// character and reciprocal constants. No dependencies.
`default_nettype none

package sdec_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned PROD_W  = 64;

  // floor(m / 10) == (m * RECIP) >> RECIP_SHIFT for every 32-bit m
  localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam int unsigned        QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT
  } sdec_state_t;

  typedef struct packed {
    logic load;        // capture sign and magnitude of a new item
    logic mul;         // form magnitude times reciprocal
    logic div;         // take quotient, store remainder digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top stored digit into the output register
  } sdec_cmd_t;

  typedef struct packed {
    logic div_done;    // quotient is zero or the digit store is full
    logic neg;         // current item is negative
    logic slot_free;   // output register can take a character this cycle
    logic last_digit;  // one digit left to emit
  } sdec_stat_t;

endpackage

`default_nettype wire

>>> design/sdec_if.sv
// Handshake channel interfaces for the converter: integer in, character out.
// Depends on sdec_pkg for payload widths.
`default_nettype none

interface sdec_in_if import sdec_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdec_out_if import sdec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink   (input valid, input character, input is_last, output ready);
endinterface

`default_nettype wire

>>> design/sdec_ctrl.sv
// Controller state machine of the converter: sequences load, digit
// extraction (multiply then divide step) and character emission.
// Depends on sdec_pkg; drives the datapath through sdec_cmd_t.
`default_nettype none

module sdec_ctrl import sdec_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire sdec_stat_t stat,
  output sdec_cmd_t       cmd
);

  sdec_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (stat.div_done) begin
          state_nxt = stat.neg ? ST_SIGN : ST_DIGIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (stat.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (stat.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.last_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/sdec_dp.sv
// Datapath of the converter: magnitude register, reciprocal multiplier,
// digit store, digit counter and the output character register.
// Depends on sdec_pkg; commanded by sdec_ctrl.
`default_nettype none

module sdec_dp import sdec_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sdec_cmd_t                 cmd,
  output sdec_stat_t                     stat,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [CHAR_W-1:0]              out_character,
  output logic                           out_is_last
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [VALUE_W-1:0] mag_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic [DIGIT_W-1:0] store_r [MAX_DIGITS];
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  logic [QUOT_W-1:0]  quot;
  logic [VALUE_W-1:0] quot_ext;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_full;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic [VALUE_W-1:0] raw;
  logic               slot_free;

  assign raw       = VALUE_W'(in_value);
  assign quot      = prod_r[PROD_W-1:RECIP_SHIFT];
  assign quot_ext  = VALUE_W'(quot);
  assign quot_x10  = (quot_ext << 3) + (quot_ext << 1);
  assign rem_full  = mag_r - quot_x10;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign slot_free = !out_valid_r || out_ready;

  assign stat.div_done   = (quot == '0) || (cnt_inc == CNT_W'(MAX_DIGITS));
  assign stat.neg        = neg_r;
  assign stat.slot_free  = slot_free;
  assign stat.last_digit = (cnt_r == CNT_W'(1));

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
      cnt_r <= '0;
      neg_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        neg_r <= raw[VALUE_W-1];
        mag_r <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
        cnt_r <= '0;
      end else if (cmd.div) begin
        mag_r <= quot_ext;
        cnt_r <= cnt_inc;
      end else if (cmd.emit_digit) begin
        cnt_r <= cnt_dec;
      end
    end
  end

  // product and digit store carry payload only
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(RECIP);
    end
    if (cmd.div) begin
      store_r[cnt_r[IDX_W-1:0]] <= rem_full[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= CHAR_ZERO + CHAR_W'(store_r[cnt_dec[IDX_W-1:0]]);
      out_last_r <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_is_last   = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> slot_free)
    else $error("character loaded over a pending result");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (cnt_r < CNT_W'(MAX_DIGITS)))
    else $error("digit store overflow");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && cnt_r == CNT_W'(1)) |=> (out_valid_r && out_last_r))
    else $error("final digit not marked last");

  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sign |=> (out_char_r == CHAR_MINUS && !out_last_r && cnt_r != '0))
    else $error("sign emitted without digits to follow");

endmodule

`default_nettype wire

>>> design/signed_int_to_decimal_ascii.sv
// Sequence: a load step, then per digit a reciprocal multiply and then a
// quotient/remainder step, then each character into the free output register.
// A new number is taken only in idle, after the last character of the previous
// one is loaded; digits use the shared multiply-by-reciprocal divide-by-ten loop.
// Reset (rst_n low, synchronous): controller to idle, output valid cleared.
`default_nettype none

module signed_int_to_decimal_ascii import sdec_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sdec_in_if.sink     in_ch,
  sdec_out_if.source  out_ch
);

  sdec_cmd_t  cmd;
  sdec_stat_t stat;
  logic       in_ready;

  sdec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sdec_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_is_last   (out_ch.is_last)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

>>> bench/tb_signed_int_to_decimal_ascii.sv
// Testbench for signed_int_to_decimal_ascii: drives signed integers, predicts
// the decimal character run of each and checks every character item.
// Depends on sdec_pkg and the sdec_in_if / sdec_out_if channel interfaces.
`default_nettype none

module tb_signed_int_to_decimal_ascii;
  import sdec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIGITS = 10;
  localparam int DIR_ROWS   = 20;
  localparam int RAND_ITEMS = 450;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              is_last;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n;
  int   errors;
  int   in_idle_pct;
  int   out_idle_pct;

  char_item_t pending_chars[$];

  sdec_in_if  in_ch ();
  sdec_out_if out_ch ();

  signed_int_to_decimal_ascii #(
    .MAX_DIGITS(NUM_DIGITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Directed values; text is filled in only where it is obvious.
  logic signed [VALUE_W-1:0] dir_value [DIR_ROWS] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
    32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
    -32'sd1000000000, 32'sd999999999, 32'sd99, 32'sd100,
    32'h5555_5555, 32'hAAAA_AAAA, 32'sd123456789, -32'sd987654321, 32'sd1073741824
  };
  string dir_text [DIR_ROWS] = '{
    "0", "1", "-1", "9", "-9", "10", "-10",
    "2147483647", "-2147483648", "-2147483647", "1000000000",
    "-1000000000", "999999999", "99", "100",
    "", "", "", "", ""
  };

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Decimal text of v, sign first, digits most significant first.
  task automatic predict_decimal(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits [20];
    int                 lim;
    int                 n;
    lim = NUM_DIGITS;
    if (lim < 1) lim = 1;
    if (lim > 20) lim = 20;
    mag = v[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(v)) : VALUE_W'(v);
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < lim);
    if (v[VALUE_W-1]) pending_chars.push_back('{CHAR_MINUS, 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      pending_chars.push_back('{CHAR_ZERO + CHAR_W'(digits[i]), (i == 0)});
    end
  endtask

  task automatic expect_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back('{CHAR_W'(s[i]), (i == s.len() - 1)});
    end
  endtask

  // Send one item; expectations are queued at the accepting edge.
  task automatic send_value(input logic signed [VALUE_W-1:0] v, input string text);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (text.len() != 0) expect_text(text);
    else predict_decimal(v);
  endtask

  // Result side: check accepted characters, then pick ready for the next edge.
  always @(posedge clk) begin
    char_item_t exp_c;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d last %0b",
                                  out_ch.character, out_ch.is_last));
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_ch.character !== exp_c.character)
          report_mismatch($sformatf("character %0d, expected %0d",
                                    out_ch.character, exp_c.character));
        if (out_ch.is_last !== exp_c.is_last)
          report_mismatch($sformatf("is_last %0b, expected %0b",
                                    out_ch.is_last, exp_c.is_last));
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic signed [VALUE_W-1:0] v;
    logic [VALUE_W-1:0]        p;
    int                        k;
    rst_n        = 1'b0;
    errors       = 0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 26;
    out_idle_pct = 70;
    for (int i = 0; i < DIR_ROWS; i++) send_value(dir_value[i], dir_text[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        in_idle_pct  = 70;
        out_idle_pct = 26;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 99);
        2: begin
          // land next to a power of ten to exercise digit-count boundaries
          k = $urandom_range(0, 9);
          p = 1;
          repeat (k) p = p * 10;
          v = p + $urandom_range(0, 2) - 1;
        end
        default: v = $urandom_range(0, 1 << $urandom_range(0, 31));
      endcase
      if ($urandom_range(0, 1)) v = -v;
      send_value(v, "");
    end
    in_ch.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
